// File: sv/sld_pkg.sv
`timescale 1ns / 1ps

package sld_pkg;

    // Sync pair that opens every frame
    localparam logic [7:0] SYNC_FIRST  = 8'hBB;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;

    // Result tag carried on the master-side tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE = 3'd0,
        KIND_TYPE = 3'd1,
        KIND_LEN  = 3'd2,
        KIND_DATA = 3'd3,
        KIND_GOOD = 3'd4,
        KIND_BAD  = 3'd5
    } t_kind;

    // Result word fields in tdata order, highest bits first
    typedef struct packed {
        logic [BYTE_W-1:0] computed_check;
        logic [BYTE_W-1:0] frame_length;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] value;
    } t_result;

endpackage

// File: sv/sync_length_xor_deframer.sv
`timescale 1ns / 1ps

// Receive-side frame parser for a byte stream framed as
//   0xBB 0xAA <type> <length> <payload x length> <check>
// where check is the XOR of both sync bytes, type, length and all payload.
//
// Slave side: one received byte per word on s_tdata.
// Master side: one result word per input word. tuser carries the kind
// (none, type, length, payload, frame good, frame bad); tdata carries the
// byte itself for type, length and payload, the payload index, the held type
// and length of the current frame and the running XOR (for good/bad: the
// value the check byte was compared to).
//
// Throughput is one word per cycle while results are taken; the parse step is
// a compare, an XOR and an 8-bit increment between the state registers and
// the result register. The result appears on m_tvalid in the cycle after the
// input is accepted. The block takes a new byte whenever the result register
// is empty or is being drained in the same cycle, so a stalled receiver stalls
// the input only while a result is waiting.
// Reset (synchronous, active low) returns the parser to hunting the first
// sync byte, clears the running XOR, count, held type and length, and
// empties the result register.
module sync_length_xor_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] value, [15:8] payload_index,
                                     // [23:16] frame_type, [31:24] frame_length,
                                     // [39:32] computed_check
    output logic [2:0]  o_m_tuser    // [2:0] kind
);

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_TYPE  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_phase;

    localparam int unsigned BW = sld_pkg::BYTE_W;

    t_phase            r_phase, n_phase;
    logic [BW-1:0]     r_check, n_check;
    logic [BW-1:0]     r_count, n_count;
    logic [BW-1:0]     r_len,   n_len;
    logic [BW-1:0]     r_type,  n_type;

    logic              r_m_valid;
    sld_pkg::t_kind    r_kind, n_kind;
    sld_pkg::t_result  r_res,  n_res;

    logic              s_accept;
    logic              m_accept;
    logic [BW-1:0]     rx;
    logic [BW-1:0]     n_value;
    logic [BW-1:0]     n_index;
    logic [BW-1:0]     count_inc;

    assign rx         = i_s_tdata;
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign m_accept   = r_m_valid && i_m_tready;
    assign count_inc  = r_count + 1'b1;

    // One parse step for the byte on the slave side
    always_comb begin
        n_phase = r_phase;
        n_check = r_check;
        n_count = r_count;
        n_len   = r_len;
        n_type  = r_type;
        n_kind  = sld_pkg::KIND_NONE;
        n_value = '0;
        n_index = '0;
        unique case (r_phase)
            PH_HUNT1: begin
                if (rx == sld_pkg::SYNC_FIRST) begin
                    n_check = sld_pkg::SYNC_FIRST;
                    n_phase = PH_HUNT2;
                end else begin
                    n_check = '0;
                end
            end
            PH_HUNT2: begin
                // a broken pair drops back to hunting without rechecking this byte
                if (rx == sld_pkg::SYNC_SECOND) begin
                    n_check = sld_pkg::SYNC_FIRST ^ sld_pkg::SYNC_SECOND;
                    n_phase = PH_TYPE;
                end else begin
                    n_check = '0;
                    n_phase = PH_HUNT1;
                end
            end
            PH_TYPE: begin
                n_type  = rx;
                n_check = r_check ^ rx;
                n_kind  = sld_pkg::KIND_TYPE;
                n_value = rx;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = rx;
                n_check = r_check ^ rx;
                n_kind  = sld_pkg::KIND_LEN;
                n_value = rx;
                n_count = '0;
                // zero length goes straight to the check byte
                n_phase = (rx != '0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
                n_check = r_check ^ rx;
                n_kind  = sld_pkg::KIND_DATA;
                n_value = rx;
                n_index = r_count;
                n_count = count_inc;
                if (count_inc >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                // check byte is compared, not folded in
                n_kind  = (r_check == rx) ? sld_pkg::KIND_GOOD : sld_pkg::KIND_BAD;
                n_phase = PH_HUNT1;
            end
            default: begin
                n_check = '0;
                n_phase = PH_HUNT1;
            end
        endcase
        n_res.value          = n_value;
        n_res.payload_index  = n_index;
        n_res.frame_type     = n_type;
        n_res.frame_length   = n_len;
        n_res.computed_check = n_check;
    end

    // Parser state and the result register; load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT1;
            r_check   <= '0;
            r_count   <= '0;
            r_len     <= '0;
            r_type    <= '0;
            r_m_valid <= 1'b0;
            r_kind    <= sld_pkg::KIND_NONE;
            r_res     <= '0;
        end else begin
            if (s_accept) begin
                r_phase   <= n_phase;
                r_check   <= n_check;
                r_count   <= n_count;
                r_len     <= n_len;
                r_type    <= n_type;
                r_m_valid <= 1'b1;
                r_kind    <= n_kind;
                r_res     <= n_res;
            end else if (m_accept) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_res;
    assign o_m_tuser  = r_kind;

    // A frame always ends by returning to the hunt
    a_check_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && r_phase == PH_CHECK |=> r_phase == PH_HUNT1)
        else $error("check byte did not return parser to hunt");

    // The type byte is tagged and held
    a_type_tagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && r_phase == PH_TYPE |=>
            r_m_valid && r_kind == sld_pkg::KIND_TYPE && r_type == $past(rx))
        else $error("type byte not tagged or held");

    // A completed sync pair seeds the running XOR
    a_sync_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && r_phase == PH_HUNT2 && rx == sld_pkg::SYNC_SECOND |=>
            r_check == (sld_pkg::SYNC_FIRST ^ sld_pkg::SYNC_SECOND) && r_phase == PH_TYPE)
        else $error("sync pair did not seed the check");

    // While in the payload the count stays below the held length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_count < r_len)
        else $error("payload count overran length");

    // A waiting result is never overwritten without being taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && !i_m_tready |=> r_m_valid && $stable(r_res) && $stable(r_kind))
        else $error("pending result lost");

endmodule

// File: tb/tb_sync_length_xor_deframer.sv
`timescale 1ns / 1ps

// Drives byte streams into the deframer and checks every result word against
// a cycle-free parser kept inside this bench. Directed bytes cover sync-pair
// corner cases, zero-length and extreme-valued frames and a bad check byte.
// Full 255-byte frames follow. Then comes a long run of mostly well-formed
// frames with random content, mixed with noise, broken sync pairs and cut-off
// headers. Both sides idle at random, and the sender stops now and then until
// every result is back.
module tb_sync_length_xor_deframer;

    localparam int unsigned RANDOM_WORDS = 1150;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned WATCHDOG_NS  = 8_000_000;

    // Parser position in the frame
    typedef enum logic [2:0] {
        ST_SEEK_SYNC1,
        ST_SEEK_SYNC2,
        ST_READ_TYPE,
        ST_READ_LEN,
        ST_READ_PAYLOAD,
        ST_READ_CHECK
    } t_parse_state;

    typedef struct packed {
        sld_pkg::t_kind   kind;
        sld_pkg::t_result fields;
    } t_parse_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] rx_byte
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;    // [7:0] value, [15:8] payload_index,
                               // [23:16] frame_type, [31:24] frame_length,
                               // [39:32] computed_check
    logic [2:0]  o_m_tuser;    // [2:0] kind

    // Parser state mirrored by the bench
    t_parse_state parse_st;
    logic [7:0]   xor_acc;
    logic [7:0]   pay_count;
    logic [7:0]   cur_len;
    logic [7:0]   cur_type;

    t_parse_result pending_q[$];
    logic [7:0]    frame_body[$];
    int unsigned   mismatches;
    int unsigned   words_sent;
    bit            src_gaps_on;
    bit            sink_gaps_on;
    int            sink_hold;

    sync_length_xor_deframer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Gap length: mostly short, now and then a long stretch
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Advance the mirrored parser by one byte and return the word it should emit
    function automatic t_parse_result parse_byte(input logic [7:0] b);
        t_parse_result r;
        r = '0;
        r.kind = sld_pkg::KIND_NONE;
        case (parse_st)
            ST_SEEK_SYNC2: begin
                if (b == sld_pkg::SYNC_SECOND) begin
                    xor_acc  = sld_pkg::SYNC_FIRST ^ sld_pkg::SYNC_SECOND;
                    parse_st = ST_READ_TYPE;
                end else begin
                    // the failing byte is dropped, never retried as a first sync
                    xor_acc  = 8'h00;
                    parse_st = ST_SEEK_SYNC1;
                end
            end
            ST_READ_TYPE: begin
                cur_type       = b;
                xor_acc        = xor_acc ^ b;
                r.kind         = sld_pkg::KIND_TYPE;
                r.fields.value = b;
                parse_st       = ST_READ_LEN;
            end
            ST_READ_LEN: begin
                cur_len        = b;
                xor_acc        = xor_acc ^ b;
                r.kind         = sld_pkg::KIND_LEN;
                r.fields.value = b;
                pay_count      = 8'h00;
                parse_st       = (b != 8'h00) ? ST_READ_PAYLOAD : ST_READ_CHECK;
            end
            ST_READ_PAYLOAD: begin
                xor_acc                = xor_acc ^ b;
                r.kind                 = sld_pkg::KIND_DATA;
                r.fields.value         = b;
                r.fields.payload_index = pay_count;
                pay_count              = pay_count + 8'd1;
                if (pay_count >= cur_len)
                    parse_st = ST_READ_CHECK;
            end
            ST_READ_CHECK: begin
                // check byte is compared, not folded into the running XOR
                r.kind   = (xor_acc == b) ? sld_pkg::KIND_GOOD : sld_pkg::KIND_BAD;
                parse_st = ST_SEEK_SYNC1;
            end
            default: begin
                if (parse_st == ST_SEEK_SYNC1 && b == sld_pkg::SYNC_FIRST) begin
                    xor_acc  = sld_pkg::SYNC_FIRST;
                    parse_st = ST_SEEK_SYNC2;
                end else begin
                    xor_acc  = 8'h00;
                    parse_st = ST_SEEK_SYNC1;
                end
            end
        endcase
        r.fields.frame_type     = cur_type;
        r.fields.frame_length   = cur_len;
        r.fields.computed_check = xor_acc;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
            flag_error($sformatf("%s mismatch: expected 0x%02h, got 0x%02h",
                                 what, want, got));
    endtask

    task automatic check_result(input sld_pkg::t_kind got_kind,
                                input sld_pkg::t_result got);
        t_parse_result want;
        if (pending_q.size() == 0) begin
            flag_error($sformatf("unexpected result word: kind %0d, data 0x%010h",
                                 got_kind, got));
            return;
        end
        want = pending_q.pop_front();
        check_field("kind", 8'(want.kind), 8'(got_kind));
        check_field("value", want.fields.value, got.value);
        check_field("payload_index", want.fields.payload_index, got.payload_index);
        check_field("frame_type", want.fields.frame_type, got.frame_type);
        check_field("frame_length", want.fields.frame_length, got.frame_length);
        check_field("computed_check", want.fields.computed_check,
                    got.computed_check);
    endtask

    // Monitor: drain result words first, then queue the prediction for any
    // word accepted on the input in the same cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                check_result(sld_pkg::t_kind'(o_m_tuser), sld_pkg::t_result'(o_m_tdata));
            if (i_s_tvalid && o_s_tready)
                pending_q.push_back(parse_byte(i_s_tdata));
        end
    end

    // Receiver: ready by default, drops ready for random stretches when enabled
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
                sink_hold = pick_gap();
                i_m_tready <= 1'b0;
                repeat (sink_hold) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // Present one byte, optionally after an idle gap, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (src_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        words_sent++;
    endtask

    // Drop valid and hold off until every expected word is back
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic fill_payload(input int len);
        frame_body.delete();
        repeat (len) frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    // Send sync pair, type, length, frame_body and check byte; spoil corrupts the check
    task automatic send_frame(input logic [7:0] ftype, input bit spoil);
        logic [7:0] len;
        logic [7:0] chk;
        len = 8'(frame_body.size());
        chk = sld_pkg::SYNC_FIRST ^ sld_pkg::SYNC_SECOND ^ ftype ^ len;
        send_byte(sld_pkg::SYNC_FIRST);
        send_byte(sld_pkg::SYNC_SECOND);
        send_byte(ftype);
        send_byte(len);
        foreach (frame_body[i]) begin
            chk = chk ^ frame_body[i];
            send_byte(frame_body[i]);
        end
        if (spoil)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    task automatic test_directed();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        // repeated first sync breaks the pair and is not retried, so the 0xAA
        // that follows lands in hunting as noise
        send_byte(sld_pkg::SYNC_FIRST);
        send_byte(sld_pkg::SYNC_FIRST);
        send_byte(sld_pkg::SYNC_SECOND);
        // zero length goes straight to the check byte
        frame_body.delete();
        send_frame(8'h7F, 1'b0);
        // payload at both extremes, good check
        frame_body.delete();
        frame_body.push_back(8'h00);
        frame_body.push_back(8'hFF);
        frame_body.push_back(sld_pkg::SYNC_FIRST);
        send_frame(8'hFF, 1'b0);
        // type and payload extremes with a wrong check byte
        frame_body.delete();
        frame_body.push_back(8'hFF);
        frame_body.push_back(8'h00);
        send_frame(8'h00, 1'b1);
        // pair broken by an ordinary byte
        send_byte(sld_pkg::SYNC_FIRST);
        send_byte(8'h00);
        drain_results();
    endtask

    // Longest frames: payload indices run 0 to 254
    task automatic test_long_frames();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b1;
        fill_payload(255);
        send_frame(8'($urandom_range(0, 255)), 1'b0);
        src_gaps_on = 1'b1;
        fill_payload(255);
        send_frame(8'($urandom_range(0, 255)), 1'b1);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        int unsigned next_mode;
        int          pick;
        int          len;
        logic [7:0]  b;
        target    = words_sent + RANDOM_WORDS;
        next_mode = words_sent;
        while (words_sent < target) begin
            // reshuffle idling every so often, including stretches with none
            if (words_sent >= next_mode) begin
                src_gaps_on  = 1'($urandom_range(0, 1));
                sink_gaps_on = 1'($urandom_range(0, 1));
                next_mode    = words_sent + 150;
            end
            len  = ($urandom_range(0, 49) == 0) ? $urandom_range(128, 255)
                                                : $urandom_range(0, 12);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                fill_payload(len);
                send_frame(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 80) begin
                fill_payload(len);
                send_frame(8'($urandom_range(0, 255)), 1'b1);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                do b = 8'($urandom_range(0, 255)); while (b == sld_pkg::SYNC_SECOND);
                send_byte(sld_pkg::SYNC_FIRST);
                send_byte(b);
            end else if (pick < 97) begin
                // cut-off header: whatever follows is read as the rest of it
                send_byte(sld_pkg::SYNC_FIRST);
                send_byte(sld_pkg::SYNC_SECOND);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                drain_results();
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = 8'h00;
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        mismatches   = 0;
        words_sent   = 0;
        parse_st     = ST_SEEK_SYNC1;
        xor_acc      = 8'h00;
        pay_count    = 8'h00;
        cur_len      = 8'h00;
        cur_type     = 8'h00;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_long_frames();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_q.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", pending_q.size()));
        if (mismatches == 0)
            $display("tb_sync_length_xor_deframer passed");
        else
            $display("tb_sync_length_xor_deframer failed");
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #(WATCHDOG_NS);
        $display("tb_sync_length_xor_deframer failed");
        $finish;
    end

endmodule

// File: sim.f
sv/sld_pkg.sv
sv/sync_length_xor_deframer.sv
tb/tb_sync_length_xor_deframer.sv
